/* rtl/core/csr_pkg.sv */
// Shared types and constants for the circle span rasterizer.
`default_nettype none

package csr_pkg;

   // Largest radius taken on start; larger requests saturate to it.
   localparam int MAX_RADIUS = 511;

   // Request kinds.
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_STEP  = 1'b1;

   // Span slots within one step.
   localparam logic [1:0] SLOT_FILL_LAST    = 2'd1;
   localparam logic [1:0] SLOT_OUTLINE_LAST = 2'd3;

   typedef struct packed {
      logic        req_type;
      logic [9:0]  center_x;
      logic [9:0]  center_y;
      logic [8:0]  radius;
      logic [15:0] pixel_color;
      logic        filled;
   } req_beat_type;

   typedef struct packed {
      logic signed [11:0] span_x;
      logic signed [11:0] span_y_top;
      logic signed [11:0] span_y_bottom;
      logic [15:0]        span_color;
      logic               last_in_step;
      logic               circle_done;
   } rsp_beat_type;

   // One walk point handed from the walker to the span output stage.
   typedef struct packed {
      logic               load;
      logic [9:0]         cx;
      logic [9:0]         cy;
      logic [15:0]        color;
      logic               filled;
      logic signed [10:0] x;
      logic [9:0]         y;
      logic               done;
   } span_load_type;

endpackage

`default_nettype wire

/* rtl/core/circle_span_rasterizer_core.sv */
// Top level of the circle span rasterizer: walker plus span output stage.
//
//   channel | dir | handshake           | beat
//   req     | in  | req_valid/req_stall | req_beat_type: start or step
//   rsp     | out | rsp_valid/rsp_stall | rsp_beat_type: one vertical span
//
// A start beat yields no span. A step beat updates the walk in the cycle it
// is taken and yields 4 spans (outline) or 2 (filled), one per cycle while
// rsp_stall is low, through the single rsp port.
// req_stall is high while a step's spans are pending, dropping in the cycle the
// last one is taken, so the next beat follows with no gap.
// Reset is synchronous: idle, no spans pending. rsp_stall holds the current span.
`default_nettype none

module circle_span_rasterizer_core #(
   parameter int MAX_RADIUS = csr_pkg::MAX_RADIUS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire csr_pkg::req_beat_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output csr_pkg::rsp_beat_type      rsp_data
);
   import csr_pkg::*;

   span_load_type load;
   logic          free;
   logic          req_accept;

   assign req_stall  = !free;
   assign req_accept = req_valid && free;

   csr_walk #(
      .MAX_RADIUS (MAX_RADIUS)
   ) u_walk (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_data   (req_data),
      .load       (load)
   );

   csr_span_out u_span_out (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* rtl/core/csr_walk.sv */
// Circle walk state and one iteration of the error-term update.
`default_nettype none

module csr_walk #(
   parameter int MAX_RADIUS = csr_pkg::MAX_RADIUS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_accept,
   input  wire csr_pkg::req_beat_type  req_data,
   output csr_pkg::span_load_type      load
);
   import csr_pkg::*;

   logic [9:0]         cx_ff, cx_in;
   logic [9:0]         cy_ff, cy_in;
   logic [15:0]        color_ff, color_in;
   logic               filled_ff, filled_in;
   logic signed [10:0] x_ff, x_in;
   logic [9:0]         y_ff, y_in;
   logic [12:0]        err_ff, err_in;
   logic               busy_ff, busy_in;

   logic        sat;
   logic [8:0]  rad;
   logic [13:0] err14, y14, x14;
   logic        e2_le_y, e2_le_x, e2_zero, e2_gt_x, done;
   logic [9:0]  y_nx;
   logic [12:0] err_a, err_b;
   logic signed [10:0] x_nx, x_fin;
   logic [11:0] negx;
   logic        step_go;

   always_comb begin
      sat = {4'b0000, req_data.radius} > 13'(MAX_RADIUS);
      rad = sat ? 9'(MAX_RADIUS) : req_data.radius;

      err14   = {err_ff[12], err_ff};
      y14     = {4'b0000, y_ff};
      x14     = {{3{x_ff[10]}}, x_ff};
      e2_le_y = $signed(err14) <= $signed(y14);
      e2_le_x = $signed(err14) <= $signed(x14);

      y_nx  = e2_le_y ? y_ff + 10'd1 : y_ff;
      err_a = e2_le_y ? err_ff + {2'b00, y_nx, 1'b1} : err_ff;

      // corner case: on the diagonal a y move also forces an x move
      negx    = 12'd0 - {x_ff[10], x_ff};
      e2_zero = e2_le_y && (negx == {2'b00, y_nx}) && e2_le_x;
      e2_gt_x = e2_zero ? x_ff[10] : !e2_le_x;

      x_nx  = x_ff + 11'sd1;
      err_b = err_a + {x_nx[10], x_nx, 1'b1};
      x_fin = e2_gt_x ? x_nx : x_ff;
      done  = !x_fin[10] && (x_fin != 11'sd0);

      step_go = req_accept && (req_data.req_type == REQ_STEP) && busy_ff;

      cx_in     = cx_ff;
      cy_in     = cy_ff;
      color_in  = color_ff;
      filled_in = filled_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      err_in    = err_ff;
      busy_in   = busy_ff;
      if (req_accept && (req_data.req_type == REQ_START)) begin
         cx_in     = req_data.center_x;
         cy_in     = req_data.center_y;
         color_in  = req_data.pixel_color;
         filled_in = req_data.filled;
         x_in      = 11'sd0 - $signed({2'b00, rad});
         y_in      = 10'd0;
         err_in    = 13'd2 - {3'b000, rad, 1'b0};
         busy_in   = 1'b1;
      end else if (step_go) begin
         x_in    = x_fin;
         y_in    = y_nx;
         err_in  = e2_gt_x ? err_b : err_a;
         busy_in = !done;
      end

      // spans use the point before the update
      load.load   = step_go;
      load.cx     = cx_ff;
      load.cy     = cy_ff;
      load.color  = color_ff;
      load.filled = filled_ff;
      load.x      = x_ff;
      load.y      = y_ff;
      load.done   = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff     <= '0;
         cy_ff     <= '0;
         color_ff  <= '0;
         filled_ff <= 1'b0;
         x_ff      <= '0;
         y_ff      <= '0;
         err_ff    <= '0;
         busy_ff   <= 1'b0;
      end else begin
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         color_ff  <= color_in;
         filled_ff <= filled_in;
         x_ff      <= x_in;
         y_ff      <= y_in;
         err_ff    <= err_in;
         busy_ff   <= busy_in;
      end
   end

   a_done_idles: assert property (@(posedge clock) disable iff (reset)
      (step_go && done) |=> !busy_ff)
      else $error("walk still busy after final iteration");

   a_walk_x_nonpos: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (x_ff[10] || x_ff == 11'sd0))
      else $error("walk x positive while busy");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.req_type == REQ_START) |=> busy_ff)
      else $error("walk not busy after start");

endmodule

`default_nettype wire

/* rtl/core/csr_span_out.sv */
// Span output stage: holds one walk point, sends one span a cycle unless stalled.
`default_nettype none

module csr_span_out (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire csr_pkg::span_load_type load,
   output logic                        free,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output csr_pkg::rsp_beat_type       rsp_data
);
   import csr_pkg::*;

   logic               pend_ff, pend_in;
   logic [1:0]         slot_ff, slot_in;
   logic [9:0]         cx_ff, cy_ff;
   logic [15:0]        color_ff;
   logic               filled_ff, done_ff;
   logic signed [10:0] x_ff;
   logic [9:0]         y_ff;

   logic [1:0]  last_slot;
   logic        is_last, taken;
   logic [11:0] col_m, col_p, row_m, row_p;

   always_comb begin
      last_slot = filled_ff ? SLOT_FILL_LAST : SLOT_OUTLINE_LAST;
      is_last   = (slot_ff == last_slot);
      taken     = pend_ff && !rsp_stall;
      free      = !pend_ff || (taken && is_last);

      pend_in = pend_ff;
      slot_in = slot_ff;
      if (load.load) begin
         pend_in = 1'b1;
         slot_in = 2'd0;
      end else if (taken) begin
         if (is_last) begin
            pend_in = 1'b0;
         end else begin
            slot_in = slot_ff + 2'd1;
         end
      end

      col_m = {2'b00, cx_ff} - {x_ff[10], x_ff};
      col_p = {2'b00, cx_ff} + {x_ff[10], x_ff};
      row_m = {2'b00, cy_ff} - {2'b00, y_ff};
      row_p = {2'b00, cy_ff} + {2'b00, y_ff};

      rsp_valid              = pend_ff;
      rsp_data.span_color    = color_ff;
      rsp_data.last_in_step  = is_last;
      rsp_data.circle_done   = is_last && done_ff;
      if (filled_ff) begin
         rsp_data.span_x        = (slot_ff == 2'd0) ? col_m : col_p;
         rsp_data.span_y_top    = row_m;
         rsp_data.span_y_bottom = row_p;
      end else begin
         // x is never positive: right-below, left-below, left-above, right-above
         case (slot_ff)
            2'd0: begin
               rsp_data.span_x = col_m;
               rsp_data.span_y_top = row_p;
            end
            2'd1: begin
               rsp_data.span_x = col_p;
               rsp_data.span_y_top = row_p;
            end
            2'd2: begin
               rsp_data.span_x = col_p;
               rsp_data.span_y_top = row_m;
            end
            default: begin
               rsp_data.span_x = col_m;
               rsp_data.span_y_top = row_m;
            end
         endcase
         rsp_data.span_y_bottom = rsp_data.span_y_top;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         slot_ff <= 2'd0;
      end else begin
         pend_ff <= pend_in;
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load.load) begin
         cx_ff     <= load.cx;
         cy_ff     <= load.cy;
         color_ff  <= load.color;
         filled_ff <= load.filled;
         x_ff      <= load.x;
         y_ff      <= load.y;
         done_ff   <= load.done;
      end
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load.load |-> free)
      else $error("span buffer overwritten while spans pending");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (slot_ff <= last_slot))
      else $error("span slot past last span of step");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (taken && is_last && !load.load) |=> !rsp_valid)
      else $error("spans continue after last beat of step");

endmodule

`default_nettype wire

/* tb/sv/circle_span_rasterizer_core_tb.sv */
// Testbench for circle_span_rasterizer_core: random and directed circles checked span by span.
`timescale 1ns / 1ps

import csr_pkg::*;

// Tracks the circle walk and holds the spans still owed by the block.
class span_scoreboard;
   rsp_beat_type span_q[$];
   int           fail_count;
   bit [9:0]     hold_cx;
   bit [9:0]     hold_cy;
   bit [15:0]    hold_color;
   bit           hold_filled;
   int           walk_x;
   int           walk_y;
   int           err_term;
   bit           busy;

   function new();
      fail_count = 0;
      busy       = 1'b0;
   endfunction

   function int wrap13(int v);
      logic signed [12:0] t;
      t = v[12:0];
      return int'(t);
   endfunction

   function void push_span(int sx, int top, int bot, bit last, bit done);
      rsp_beat_type s;
      s.span_x        = sx[11:0];
      s.span_y_top    = top[11:0];
      s.span_y_bottom = bot[11:0];
      s.span_color    = hold_color;
      s.last_in_step  = last;
      s.circle_done   = done;
      span_q.push_back(s);
   endfunction

   // Returns 1 when the beat changed state or produced spans.
   function bit note_req(req_beat_type b);
      int r;
      int cx;
      int cy;
      int x;
      int y;
      int e2;
      bit done;
      if (b.req_type == REQ_START) begin
         r = int'(b.radius);
         if (r > MAX_RADIUS) r = MAX_RADIUS;
         hold_cx     = b.center_x;
         hold_cy     = b.center_y;
         hold_color  = b.pixel_color;
         hold_filled = b.filled;
         walk_x      = -r;
         walk_y      = 0;
         err_term    = wrap13(2 - 2 * r);
         busy        = 1'b1;
         return 1'b1;
      end
      if (!busy) return 1'b0;
      cx = int'(hold_cx);
      cy = int'(hold_cy);
      x  = walk_x;
      y  = walk_y;
      e2 = err_term;
      if (e2 <= walk_y) begin
         walk_y   = walk_y + 1;
         err_term = wrap13(err_term + walk_y * 2 + 1);
         // corner adjustment on the diagonal
         if (-walk_x == walk_y && e2 <= walk_x) e2 = 0;
      end
      if (e2 > walk_x) begin
         walk_x   = walk_x + 1;
         err_term = wrap13(err_term + walk_x * 2 + 1);
      end
      done = (walk_x > 0);
      if (done) busy = 1'b0;
      if (hold_filled) begin
         push_span(cx - x, cy - y, cy + y, 1'b0, 1'b0);
         push_span(cx + x, cy - y, cy + y, 1'b1, done);
      end else begin
         push_span(cx - x, cy + y, cy + y, 1'b0, 1'b0);
         push_span(cx + x, cy + y, cy + y, 1'b0, 1'b0);
         push_span(cx + x, cy - y, cy - y, 1'b0, 1'b0);
         push_span(cx - x, cy - y, cy - y, 1'b1, done);
      end
      return 1'b1;
   endfunction

   task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      fail_count++;
   endtask

   task check_span(rsp_beat_type got);
      rsp_beat_type want;
      if (span_q.size() == 0) begin
         report_mismatch($sformatf("unexpected span %h", got));
         return;
      end
      want = span_q.pop_front();
      if (got.span_x !== want.span_x)
         report_mismatch($sformatf("span_x got %0d want %0d", got.span_x, want.span_x));
      if (got.span_y_top !== want.span_y_top)
         report_mismatch($sformatf("span_y_top got %0d want %0d",
                                   got.span_y_top, want.span_y_top));
      if (got.span_y_bottom !== want.span_y_bottom)
         report_mismatch($sformatf("span_y_bottom got %0d want %0d",
                                   got.span_y_bottom, want.span_y_bottom));
      if (got.span_color !== want.span_color)
         report_mismatch($sformatf("span_color got %h want %h",
                                   got.span_color, want.span_color));
      if (got.last_in_step !== want.last_in_step)
         report_mismatch($sformatf("last_in_step got %b want %b",
                                   got.last_in_step, want.last_in_step));
      if (got.circle_done !== want.circle_done)
         report_mismatch($sformatf("circle_done got %b want %b",
                                   got.circle_done, want.circle_done));
   endtask
endclass

module circle_span_rasterizer_core_tb;
   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_beat_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_beat_type rsp_data;

   span_scoreboard sb;
   int send_idle_pct;
   int recv_idle_pct;
   int taken_items;

   circle_span_rasterizer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   initial begin
      #(12 * 1_000_000);
      $display("circle_span_rasterizer_core_tb: errors");
      $finish;
   end

   // Receiver back-pressure.
   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_span(rsp_data);
   end

   function req_beat_type rand_beat();
      req_beat_type b;
      b.req_type    = 1'($urandom_range(1));
      b.center_x    = 10'($urandom_range(1023));
      b.center_y    = 10'($urandom_range(1023));
      b.radius      = 9'($urandom_range(511));
      b.pixel_color = 16'($urandom_range(65535));
      b.filled      = 1'($urandom_range(1));
      return b;
   endfunction

   function req_beat_type step_beat();
      req_beat_type b;
      b          = rand_beat();
      b.req_type = REQ_STEP;
      return b;
   endfunction

   function req_beat_type start_beat(int cx, int cy, int r, int color, bit fill);
      req_beat_type b;
      b.req_type    = REQ_START;
      b.center_x    = 10'(cx);
      b.center_y    = 10'(cy);
      b.radius      = 9'(r);
      b.pixel_color = 16'(color);
      b.filled      = fill;
      return b;
   endfunction

   // Entered and left at a falling edge.
   task send_req(req_beat_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = b;
      do @(posedge clock); while (req_stall);
      if (sb.note_req(b)) taken_items++;
      @(negedge clock);
   endtask

   task finish_circle();
      while (sb.busy) send_req(step_beat());
   endtask

   task run_circle(req_beat_type b);
      send_req(b);
      finish_circle();
   endtask

   task run_random(int target);
      int           stop_at;
      int           pick;
      req_beat_type b;
      stop_at = taken_items + target;
      while (taken_items < stop_at) begin
         pick         = $urandom_range(99);
         b            = rand_beat();
         b.req_type   = REQ_START;
         if (pick < 65) begin
            b.radius = 9'($urandom_range(14));
            run_circle(b);
         end else if (pick < 82) begin
            // random-radius circle, run for up to 16 steps and then left
            send_req(b);
            repeat ($urandom_range(16, 1)) send_req(step_beat());
         end else if (pick < 92) begin
            send_req(b);
            b        = rand_beat();
            b.req_type = REQ_START;
            b.radius = 9'($urandom_range(6));
            run_circle(b);
         end else begin
            repeat ($urandom_range(3, 1)) send_req(step_beat());
         end
      end
   endtask

   initial begin
      sb            = new();
      taken_items   = 0;
      send_idle_pct = 8;
      recv_idle_pct = 74;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_stall     = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // step with nothing loaded
      send_req(step_beat());
      // zero and small radii, both modes, corner centers and color extremes
      run_circle(start_beat(0, 0, 0, 16'h0000, 1'b0));
      send_req(step_beat());
      run_circle(start_beat(1023, 1023, 0, 16'hFFFF, 1'b1));
      run_circle(start_beat(1023, 0, 1, 16'hA5A5, 1'b0));
      run_circle(start_beat(0, 1023, 2, 16'h5A5A, 1'b1));
      // largest radius, then restart while busy
      send_req(start_beat(512, 512, MAX_RADIUS, 16'hFFFF, 1'b0));
      repeat (3) send_req(step_beat());
      send_req(start_beat(0, 0, MAX_RADIUS, 16'h0001, 1'b1));
      repeat (3) send_req(step_beat());
      run_circle(start_beat(1023, 1023, 3, 16'h8000, 1'b0));

      run_random(70);
      send_idle_pct = 74;
      recv_idle_pct = 8;
      run_random(70);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(70);
      // one full mid-size circle off the top-right corner
      run_circle(start_beat(1023, 0, 60, 16'h7E0F, 1'b0));

      req_valid = 1'b0;
      while (sb.span_q.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (sb.fail_count == 0 && sb.span_q.size() == 0) begin
         $display("circle_span_rasterizer_core_tb: clean");
      end else begin
         $display("circle_span_rasterizer_core_tb: errors");
      end
      $finish;
   end
endmodule
